// ===== rtl/core/rfla_pkg.sv =====
// shared types and constants for the reference free-list allocator
`timescale 1ns / 1ps
`default_nettype none

package rfla_pkg;

  localparam int CAPACITY    = 256;
  localparam int VALUE_WIDTH = 32;
  localparam int IN_VAL_W    = 32;
  localparam int REF_W       = 10;
  localparam int HANDLE_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W      = $clog2(CAPACITY);

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NIL     = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_IGNORED = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/rfla_req_if.sv =====
// request channel of the allocator
`timescale 1ns / 1ps
`default_nettype none

interface rfla_req_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [rfla_pkg::IN_VAL_W-1:0]       value;
  logic                                value_is_nil;
  logic signed [rfla_pkg::REF_W-1:0]   release_ref;

  modport source (
    output valid, operation, value, value_is_nil, release_ref,
    input  ready
  );

  modport sink (
    input  valid, operation, value, value_is_nil, release_ref,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/rfla_rsp_if.sv =====
// response channel of the allocator
`timescale 1ns / 1ps
`default_nettype none

interface rfla_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [rfla_pkg::REF_W-1:0] ref_out;
  logic [1:0]                        status;

  modport source (
    output valid, ref_out, status,
    input  ready
  );

  modport sink (
    input  valid, ref_out, status,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/reference_free_list_allocator.sv =====
// top level: reference handle allocator with a LIFO free list
// sequence: accept registers the request and reads the link memory at the free-list head;
// commit then updates the handle state and loads the result register
// a new request is taken only after the previous one has committed
// a result waiting at the output holds the commit, not the next accept
// reset: clears free-list head, high-water mark, fsm and output valid; memories are not cleared
`timescale 1ns / 1ps
`default_nettype none

module reference_free_list_allocator (
  input  logic       clk,
  input  logic       rst,
  rfla_req_if.sink   req,
  rfla_rsp_if.source rsp
);

  rfla_pkg::cmd_t  cmd;
  rfla_pkg::stat_t stat;
  logic            in_ready;

  assign req.ready = in_ready;

  rfla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rfla_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .operation    (req.operation),
    .value        (req.value),
    .value_is_nil (req.value_is_nil),
    .release_ref  (req.release_ref),
    .rsp          (rsp)
  );

endmodule

`default_nettype wire

// ===== rtl/core/rfla_ctrl.sv =====
// sequencing state machine of the allocator
`timescale 1ns / 1ps
`default_nettype none

module rfla_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rfla_pkg::stat_t stat,
  output rfla_pkg::cmd_t  cmd
);

  rfla_pkg::state_t state;
  rfla_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rfla_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      rfla_pkg::ST_IDLE: begin
        // no request is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.accept = 1'b1;
          state_next = rfla_pkg::ST_EXEC;
        end
      end
      rfla_pkg::ST_EXEC: begin
        // commit only once the result register can take the result
        if (stat.out_free) begin
          cmd.exec   = 1'b1;
          state_next = rfla_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rfla_pkg::ST_IDLE;
      end
    endcase
  end

  a_exec_in_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> (state == rfla_pkg::ST_EXEC) && stat.out_free)
    else $error("commit outside execute state");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == rfla_pkg::ST_EXEC))
    else $error("accepted request not executed");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.accept && cmd.exec))
    else $error("accept and commit in one cycle");

endmodule

`default_nettype wire

// ===== rtl/core/rfla_datapath.sv =====
// handle state, link and value memories, result register
`timescale 1ns / 1ps
`default_nettype none

module rfla_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  rfla_pkg::cmd_t                    cmd,
  output rfla_pkg::stat_t                   stat,
  input  logic                              operation,
  input  logic [rfla_pkg::IN_VAL_W-1:0]     value,
  input  logic                              value_is_nil,
  input  logic signed [rfla_pkg::REF_W-1:0] release_ref,
  rfla_rsp_if.source                        rsp
);

  localparam int HW = rfla_pkg::HANDLE_W;
  localparam int AW = rfla_pkg::ADDR_W;
  localparam int RW = rfla_pkg::REF_W;
  localparam int VW = rfla_pkg::VALUE_WIDTH;

  // control state
  logic [HW-1:0] head;
  logic [HW-1:0] head_next;
  logic [HW-1:0] hw;
  logic [HW-1:0] hw_next;
  logic          out_valid;

  // captured request
  logic                 op_q;
  logic [VW-1:0]        val_q;
  logic                 nil_q;
  logic signed [RW-1:0] rel_q;

  logic [HW-1:0] link_rdata;
  logic [HW-1:0] link_mem [rfla_pkg::CAPACITY];
  logic [VW-1:0] value_mem [rfla_pkg::CAPACITY];

  logic signed [RW-1:0] out_ref;
  rfla_pkg::status_t    out_status;

  logic [HW-1:0] head_dec;
  logic [AW-1:0] head_idx;

  logic signed [RW-1:0] res_ref;
  rfla_pkg::status_t    res_status;
  logic [HW-1:0]        handle;
  logic [HW-1:0]        handle_dec;
  logic [AW-1:0]        mem_idx;
  logic                 val_we;
  logic [VW-1:0]        val_wdata;
  logic                 link_we;
  logic [RW-1:0]        rel_u;
  logic                 rel_ok;

  assign head_dec   = head - HW'(1);
  assign head_idx   = head_dec[AW-1:0];
  assign handle_dec = handle - HW'(1);
  assign mem_idx    = handle_dec[AW-1:0];

  assign rel_u  = $unsigned(rel_q);
  assign rel_ok = !rel_q[RW-1] && (rel_u != '0) && (rel_u <= RW'(hw));

  always_comb begin
    res_ref    = '0;
    res_status = rfla_pkg::STAT_OK;
    head_next  = head;
    hw_next    = hw;
    handle     = head;
    val_we     = 1'b0;
    val_wdata  = val_q;
    link_we    = 1'b0;
    if (op_q == rfla_pkg::OP_ALLOC) begin
      priority if (nil_q) begin
        res_ref    = '1;
        res_status = rfla_pkg::STAT_NIL;
      end else if (head != '0) begin
        // reuse the most recently released handle
        handle    = head;
        head_next = link_rdata;
        val_we    = 1'b1;
        res_ref   = RW'(handle);
      end else if (hw != HW'(rfla_pkg::CAPACITY)) begin
        handle  = hw + HW'(1);
        hw_next = handle;
        val_we  = 1'b1;
        res_ref = RW'(handle);
      end else begin
        res_status = rfla_pkg::STAT_FULL;
      end
    end else begin
      if (rel_ok) begin
        handle    = rel_u[HW-1:0];
        head_next = handle;
        link_we   = 1'b1;
        val_we    = 1'b1;
        val_wdata = '0;
      end else begin
        res_status = rfla_pkg::STAT_IGNORED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      hw   <= '0;
    end else if (cmd.exec) begin
      head <= head_next;
      hw   <= hw_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q  <= operation;
      val_q <= value[VW-1:0];
      nil_q <= value_is_nil;
      rel_q <= release_ref;
    end
  end

  // link read at the free-list head is issued on accept, used on commit
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      link_rdata <= link_mem[head_idx];
    end
    if (cmd.exec && link_we) begin
      link_mem[mem_idx] <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && val_we) begin
      value_mem[mem_idx] <= val_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_ref    <= res_ref;
      out_status <= res_status;
    end
  end

  assign stat.out_free = !out_valid || rsp.ready;
  assign rsp.valid     = out_valid;
  assign rsp.ref_out   = out_ref;
  assign rsp.status    = out_status;

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    head <= hw)
    else $error("free-list head beyond high-water mark");

  a_hw_range: assert property (@(posedge clk) disable iff (rst)
    hw <= HW'(rfla_pkg::CAPACITY))
    else $error("high-water mark beyond capacity");

  a_hw_monotonic: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> (hw == $past(hw)) || (hw == $past(hw) + HW'(1)))
    else $error("high-water mark moved by more than one");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rsp.ready |=> out_valid && $stable(out_ref))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for the reference free-list allocator
`timescale 1ns / 1ps

module tb_top;
  import rfla_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    op_t                     op;
    logic [IN_VAL_W-1:0]     value;
    logic                    value_is_nil;
    logic signed [REF_W-1:0] release_ref;
  } handle_req_t;

  typedef struct {
    logic signed [REF_W-1:0] ref_out;
    status_t                 status;
  } handle_rsp_t;

  class handle_ledger;
    logic [HANDLE_W-1:0]    free_head;
    logic [HANDLE_W-1:0]    high_water;
    logic [HANDLE_W-1:0]    link_mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] value_mem [CAPACITY];
    handle_rsp_t            awaited_responses[$];
    int                     live[$];  // handles handed out and not yet released
    int                     mismatches;
    bit                     seen_full;

    function new();
      free_head  = '0;
      high_water = '0;
      mismatches = 0;
      seen_full  = 1'b0;
    endfunction

    // applies one request to the handle state and returns the response it causes
    function handle_rsp_t allocate_or_release(handle_req_t r);
      handle_rsp_t res;
      int          rel;
      int          h;
      int          idx[$];
      res.ref_out = '0;
      res.status  = STAT_OK;
      rel = r.release_ref;
      if (r.op == OP_ALLOC) begin
        if (r.value_is_nil) begin
          res.ref_out = '1;
          res.status  = STAT_NIL;
          return res;
        end
        if (free_head != 0) begin
          h = free_head;
          free_head = link_mem[h-1];
        end else if (high_water < CAPACITY) begin
          high_water++;
          h = high_water;
        end else begin
          res.status = STAT_FULL;
          seen_full  = 1'b1;
          return res;
        end
        value_mem[h-1] = r.value[VALUE_WIDTH-1:0];
        live.push_back(h);
        res.ref_out = REF_W'(h);
      end else if (rel < 1 || rel > int'(high_water)) begin
        res.status = STAT_IGNORED;
      end else begin
        link_mem[rel-1]  = free_head;
        free_head        = HANDLE_W'(rel);
        value_mem[rel-1] = '0;
        idx = live.find_first_index(x) with (x == rel);
        if (idx.size() != 0) live.delete(idx[0]);
      end
      return res;
    endfunction

    function void note_request(handle_req_t r);
      awaited_responses.push_back(allocate_or_release(r));
    endfunction

    function void check_response(handle_rsp_t got);
      handle_rsp_t want;
      if (awaited_responses.size() == 0) begin
        $display("%0t: response with none awaited, ref_out %0d status %0d",
                 $time, got.ref_out, got.status);
        mismatches++;
        return;
      end
      want = awaited_responses.pop_front();
      if (got.ref_out !== want.ref_out) begin
        $display("%0t: ref_out expected %0d actual %0d", $time, want.ref_out, got.ref_out);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst;
  int unsigned  cycle_count = 0;
  int           tx_idle_pct = 6;
  int           rx_idle_pct = 53;
  handle_ledger ledger;

  rfla_req_if req_ch ();
  rfla_rsp_if rsp_ch ();

  reference_free_list_allocator uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic handle_req_t make_req(op_t op, logic [IN_VAL_W-1:0] v, logic nil,
                                           int rel);
    handle_req_t r;
    r.op           = op;
    r.value        = v;
    r.value_is_nil = nil;
    r.release_ref  = REF_W'(rel);
    return r;
  endfunction

  // mostly well-formed traffic: some releases use invalid refs, others pick live handles or, if allowed, a double free
  function automatic handle_req_t random_request(int release_pct, bit allow_double);
    handle_req_t r;
    int          roll;
    roll = $urandom_range(99);
    r.op           = OP_ALLOC;
    r.value_is_nil = 1'b0;
    r.release_ref  = REF_W'($urandom_range(1023));
    if ($urandom_range(9) == 0) r.value = $urandom_range(1) ? '1 : '0;
    else r.value = $urandom;
    if (roll < 8) begin
      r.value_is_nil = 1'b1;
    end else if (roll < 14) begin
      r.op           = OP_RELEASE;
      r.value_is_nil = 1'($urandom_range(1));
      case ($urandom_range(2))
        0: r.release_ref = '0;
        1: r.release_ref = '1;
        default: begin
          if (ledger.high_water < CAPACITY)
            r.release_ref = REF_W'($urandom_range(CAPACITY, ledger.high_water + 1));
          else
            r.release_ref = '0;
        end
      endcase
    end else if (roll < 14 + release_pct) begin
      r.op           = OP_RELEASE;
      r.value_is_nil = 1'($urandom_range(1));
      if (allow_double && $urandom_range(9) == 0 && ledger.high_water != 0)
        r.release_ref = REF_W'($urandom_range(ledger.high_water, 1));
      else if (ledger.live.size() != 0)
        r.release_ref = REF_W'(ledger.live[$urandom_range(ledger.live.size() - 1)]);
      else
        r.release_ref = '0;
    end
    return r;
  endfunction

  task automatic send_request(handle_req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.operation    <= r.op;
    req_ch.value        <= r.value;
    req_ch.value_is_nil <= r.value_is_nil;
    req_ch.release_ref  <= r.release_ref;
    do @(posedge clk); while (!req_ch.ready);
    ledger.note_request(r);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (ledger.awaited_responses.size() != 0) @(posedge clk);
  endtask

  initial begin
    handle_rsp_t seen;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        seen.ref_out = rsp_ch.ref_out;
        seen.status  = status_t'(rsp_ch.status);
        ledger.check_response(seen);
      end
      rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    int h;
    ledger = new();
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.operation    <= OP_ALLOC;
    req_ch.value        <= '0;
    req_ch.value_is_nil <= 1'b0;
    req_ch.release_ref  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, ignored releases, lifo reuse, nil with a non-empty free list
    send_request(make_req(OP_ALLOC, '0, 1'b0, 0));
    send_request(make_req(OP_ALLOC, '1, 1'b0, -1));
    send_request(make_req(OP_ALLOC, '1, 1'b1, -1));
    send_request(make_req(OP_RELEASE, '0, 1'b0, 0));
    send_request(make_req(OP_RELEASE, '1, 1'b1, -1));
    send_request(make_req(OP_RELEASE, '0, 1'b0, CAPACITY));
    send_request(make_req(OP_RELEASE, '0, 1'b0, 3));
    send_request(make_req(OP_RELEASE, '1, 1'b1, 1));
    send_request(make_req(OP_RELEASE, 32'h5a5a_a5a5, 1'b0, 2));
    send_request(make_req(OP_ALLOC, 32'h1234_5678, 1'b0, CAPACITY));
    send_request(make_req(OP_ALLOC, 32'h8000_0001, 1'b0, 0));
    send_request(make_req(OP_ALLOC, '1, 1'b0, 1));
    send_request(make_req(OP_RELEASE, '0, 1'b1, 3));
    send_request(make_req(OP_ALLOC, '0, 1'b1, 0));
    send_request(make_req(OP_ALLOC, 32'hdead_beef, 1'b0, 0));
    wait_drained();

    // allocation heavy traffic, to drive the store toward full
    repeat (265) send_request(random_request(10, 1'b0));
    wait_drained();

    tx_idle_pct = 53;
    rx_idle_pct = 6;
    repeat (265) send_request(random_request(20, 1'b0));
    while (!ledger.seen_full) send_request(make_req(OP_ALLOC, $urandom, 1'b0, 0));
    wait_drained();

    // double frees only now: they leave a cycle in the free list for good
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    if (ledger.live.size() != 0) begin
      h = ledger.live[0];
      send_request(make_req(OP_RELEASE, '0, 1'b0, h));
      send_request(make_req(OP_RELEASE, '0, 1'b0, h));
      repeat (3) send_request(make_req(OP_ALLOC, $urandom, 1'b0, 0));
    end
    repeat (265) send_request(random_request(45, 1'b1));
    wait_drained();
    repeat (10) @(posedge clk);

    if (ledger.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
